@@ rtl/nnfs_pkg.sv @@
// ----------------------------------------------------------------------------
// nnfs_pkg
// shared types, geometry constants and pixel conversion for the frame scaler
// ----------------------------------------------------------------------------
package nnfs_pkg;

  // source and screen geometry
  localparam int unsigned SRC_WIDTH  = 160;
  localparam int unsigned SRC_HEIGHT = 160;
  localparam int unsigned OUT_WIDTH  = 320;
  localparam int unsigned OUT_HEIGHT = 240;

  // frame store
  localparam int unsigned STORE_SIZE = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned STORE_AW   = $clog2(STORE_SIZE);

  // payload widths fixed by the interface
  localparam int unsigned ADDR_IN_W = 15;
  localparam int unsigned PIX_IN_W  = 15;
  localparam int unsigned PIX_OUT_W = 16;
  localparam int unsigned DEST_W    = 17;

  // 9.16 sampling accumulators
  localparam int unsigned ACC_W  = 25;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned SMP_W  = ACC_W - FRAC_W;

  localparam logic [ACC_W-1:0] XSTEP_FULL = ACC_W'((SRC_WIDTH << FRAC_W) / OUT_WIDTH);
  localparam logic [ACC_W-1:0] YSTEP_FULL = ACC_W'((SRC_HEIGHT << FRAC_W) / OUT_HEIGHT);
  localparam logic [ACC_W-1:0] STEP_ORIG  = ACC_W'(1 << FRAC_W);

  // position counters
  localparam int unsigned MAX_COLS = (OUT_WIDTH > SRC_WIDTH) ? OUT_WIDTH : SRC_WIDTH;
  localparam int unsigned MAX_ROWS = (OUT_HEIGHT > SRC_HEIGHT) ? OUT_HEIGHT : SRC_HEIGHT;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);

  localparam logic [COL_W-1:0] LAST_COL_FULL = COL_W'(OUT_WIDTH - 1);
  localparam logic [COL_W-1:0] LAST_COL_ORIG = COL_W'(SRC_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW_FULL = ROW_W'(OUT_HEIGHT - 1);
  localparam logic [ROW_W-1:0] LAST_ROW_ORIG = ROW_W'(SRC_HEIGHT - 1);

  // centering offsets for original size mode
  localparam int unsigned OFF_X = (OUT_WIDTH >= SRC_WIDTH) ? (OUT_WIDTH - SRC_WIDTH) / 2 : 0;
  localparam int unsigned OFF_Y = (OUT_HEIGHT >= SRC_HEIGHT) ? (OUT_HEIGHT - SRC_HEIGHT) / 2 : 0;

  // codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EMIT  = 1'b1;
  localparam logic MODE_ORIG  = 1'b0;
  localparam logic MODE_FULL  = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [ADDR_IN_W-1:0] src_addr;
    logic [PIX_IN_W-1:0]  src_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_OUT_W-1:0] out_pixel;
    logic [DEST_W-1:0]    dest_addr;
    logic                 line_end;
    logic                 frame_end;
  } out_item_t;

  // everything about one output pixel except the pixel itself
  typedef struct packed {
    logic              sample_ok;
    logic [DEST_W-1:0] dest_addr;
    logic              line_end;
    logic              frame_end;
  } pix_meta_t;

  typedef struct packed {
    logic [STORE_AW-1:0] rd_addr;
    pix_meta_t           meta;
  } pos_info_t;

  // rgb555 to rgb565, green low bit zero
  function automatic logic [PIX_OUT_W-1:0] to_rgb565(input logic [PIX_IN_W-1:0] p);
    return {p[14:5], 1'b0, p[4:0]};
  endfunction

endpackage

@@ rtl/nnfs_ram.sv @@
// ----------------------------------------------------------------------------
// nnfs_ram
// generic single port ram, registered read, no reset on the array
// ----------------------------------------------------------------------------
module nnfs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nnfs_pos.sv @@
// ----------------------------------------------------------------------------
// nnfs_pos
// output position counters, sampling accumulators and address generation
// ----------------------------------------------------------------------------
module nnfs_pos (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                mode_i,
  output nnfs_pkg::pos_info_t info_o
);

  logic [nnfs_pkg::ACC_W-1:0] x_acc_q, x_acc_d;
  logic [nnfs_pkg::ACC_W-1:0] y_acc_q, y_acc_d;
  logic [nnfs_pkg::COL_W-1:0] col_q, col_d;
  logic [nnfs_pkg::ROW_W-1:0] row_q, row_d;

  logic                        full;
  logic [nnfs_pkg::ACC_W-1:0]  xstep, ystep;
  logic [nnfs_pkg::COL_W-1:0]  last_col;
  logic [nnfs_pkg::ROW_W-1:0]  last_row;
  logic [nnfs_pkg::SMP_W-1:0]  sx, sy;
  logic [31:0]                 idx;
  logic [31:0]                 row_eff, col_eff, dest;
  logic                        lend, fend;

  always_comb begin
    full     = (mode_i == nnfs_pkg::MODE_FULL);
    xstep    = full ? nnfs_pkg::XSTEP_FULL : nnfs_pkg::STEP_ORIG;
    ystep    = full ? nnfs_pkg::YSTEP_FULL : nnfs_pkg::STEP_ORIG;
    last_col = full ? nnfs_pkg::LAST_COL_FULL : nnfs_pkg::LAST_COL_ORIG;
    last_row = full ? nnfs_pkg::LAST_ROW_FULL : nnfs_pkg::LAST_ROW_ORIG;

    // integer part of the accumulators picks the source pixel
    sx  = x_acc_q[nnfs_pkg::ACC_W-1:nnfs_pkg::FRAC_W];
    sy  = y_acc_q[nnfs_pkg::ACC_W-1:nnfs_pkg::FRAC_W];
    idx = 32'(sy) * 32'(nnfs_pkg::SRC_WIDTH) + 32'(sx);

    row_eff = 32'(row_q) + (full ? 32'd0 : 32'(nnfs_pkg::OFF_Y));
    col_eff = 32'(col_q) + (full ? 32'd0 : 32'(nnfs_pkg::OFF_X));
    dest    = row_eff * 32'(nnfs_pkg::OUT_WIDTH) + col_eff;

    // a counter past the mode's last position counts as the last one
    lend = (col_q >= last_col);
    fend = lend && (row_q >= last_row);

    info_o.rd_addr        = idx[nnfs_pkg::STORE_AW-1:0];
    info_o.meta.sample_ok = (32'(sx) < 32'(nnfs_pkg::SRC_WIDTH)) &&
                            (32'(sy) < 32'(nnfs_pkg::SRC_HEIGHT));
    info_o.meta.dest_addr = dest[nnfs_pkg::DEST_W-1:0];
    info_o.meta.line_end  = lend;
    info_o.meta.frame_end = fend;
  end

  always_comb begin
    x_acc_d = x_acc_q;
    y_acc_d = y_acc_q;
    col_d   = col_q;
    row_d   = row_q;
    if (step_i) begin
      if (fend) begin
        x_acc_d = '0;
        y_acc_d = '0;
        col_d   = '0;
        row_d   = '0;
      end else if (lend) begin
        x_acc_d = '0;
        y_acc_d = y_acc_q + ystep;
        col_d   = '0;
        row_d   = row_q + 1'b1;
      end else begin
        x_acc_d = x_acc_q + xstep;
        col_d   = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc_q <= '0;
      y_acc_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      x_acc_q <= x_acc_d;
      y_acc_q <= y_acc_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fend) |=> (col_q == '0 && row_q == '0 && x_acc_q == '0 && y_acc_q == '0))
    else $error("position not cleared after frame end");

  a_line_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && lend && !fend) |=> (col_q == '0 && x_acc_q == '0 &&
                                   row_q == $past(row_q) + 1'b1))
    else $error("bad line wrap");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(col_q) && $stable(row_q) && $stable(x_acc_q) && $stable(y_acc_q)))
    else $error("position moved without an emit");

endmodule

@@ rtl/nearest_neighbor_frame_scaler.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_frame_scaler
// rgb555 frame store with nearest neighbor scaling to an rgb565 screen
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                      carries
//  -------   ---------  ---------------------------  ---------------------------
//  in        sink       in_valid_i/in_ready_o        write or emit request
//  out       source     out_valid_o/out_ready_i      rgb565 pixel, screen address
//  cfg       sink       cfg_we_i/cfg_data_i          scale_mode, no wait
//
//  one transfer per clock on the input when the output keeps up
//  emit: frame store read and position captured at the input transfer, pixel
//  moves from the read stage into the output register, then to the output port
//  write: into the frame store port at the input transfer, no output transfer
//  a stalled output holds one pixel in flight plus one in the output register
//  reset clears position and scale_mode, the frame store keeps its contents
//
module nearest_neighbor_frame_scaler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nnfs_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nnfs_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i
);

  logic scale_mode_q;

  // input transfer decode
  logic in_xfer, is_emit, wr_in_range;
  logic ram_en, ram_we;
  logic [nnfs_pkg::STORE_AW-1:0] ram_addr;
  logic [nnfs_pkg::PIX_IN_W-1:0] ram_rdata;

  nnfs_pkg::pos_info_t pos_info;

  // read stage: waits for the ram data
  logic                rd_valid_q, rd_valid_d;
  nnfs_pkg::pix_meta_t rd_meta_q;
  logic                rd_advance;

  // output register
  logic                out_valid_q, out_valid_d;
  nnfs_pkg::out_item_t out_data_q;

  // scale mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q <= nnfs_pkg::MODE_ORIG;
    end else if (cfg_we_i) begin
      scale_mode_q <= cfg_data_i;
    end
  end

  // the read stage moves on whenever the output register is free or draining
  assign rd_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !rd_valid_q || rd_advance;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign is_emit     = (in_data_i.func == nnfs_pkg::FUNC_EMIT);
  assign wr_in_range = (32'(in_data_i.src_addr) < 32'(nnfs_pkg::STORE_SIZE));

  // writes out of range are dropped
  assign ram_en   = in_xfer && (is_emit || wr_in_range);
  assign ram_we   = !is_emit;
  assign ram_addr = is_emit ? pos_info.rd_addr
                            : nnfs_pkg::STORE_AW'(in_data_i.src_addr);

  nnfs_ram #(
    .Width (nnfs_pkg::PIX_IN_W),
    .Depth (nnfs_pkg::STORE_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.src_pixel),
    .rdata_o (ram_rdata)
  );

  // position advances on every emit transfer
  nnfs_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer && is_emit),
    .mode_i (scale_mode_q),
    .info_o (pos_info)
  );

  // read stage and output register control
  always_comb begin
    rd_valid_d = rd_valid_q;
    if (rd_valid_q && rd_advance) begin
      rd_valid_d = 1'b0;
    end
    if (in_xfer && is_emit) begin
      rd_valid_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (rd_valid_q && rd_advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer && is_emit) begin
      rd_meta_q <= pos_info.meta;
    end
    if (rd_valid_q && rd_advance) begin
      // samples outside the source read as black
      out_data_q.out_pixel <= rd_meta_q.sample_ok ? nnfs_pkg::to_rgb565(ram_rdata) : '0;
      out_data_q.dest_addr <= rd_meta_q.dest_addr;
      out_data_q.line_end  <= rd_meta_q.line_end;
      out_data_q.frame_end <= rd_meta_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && out_valid_q && !out_ready_i) |=> (rd_valid_q && $stable(rd_meta_q)))
    else $error("pending read lost under output stall");

  a_emit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_emit) |=> rd_valid_q)
    else $error("emit transfer did not reach read stage");

  a_no_ram_op_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && !rd_advance) |-> !ram_en)
    else $error("ram accessed while read data still pending");

  a_frame_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_data_q.frame_end || out_data_q.line_end))
    else $error("frame end without line end");

endmodule
